>>> hw/rtl/spring_force_3d_assert.svh
// ----------------------------------------------------------------------------
// spring_force_3d assertion macros
// Clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPRING_FORCE_3D_ASSERT_SVH
`define SPRING_FORCE_3D_ASSERT_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spring_force_3d: same-cycle check failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spring_force_3d: next-cycle check failed");

`endif

>>> hw/rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Widths, register codes and payload types of the spring force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	localparam int CW   = 32;
	localparam int FB   = 16;
	localparam int MW   = CW;
	localparam int SQW  = 2 * MW;
	localparam int SUMW = SQW + 2;
	localparam int LW   = SUMW / 2;
	localparam int GW   = FB + 1;
	localparam int RLW  = CW - 1;
	localparam int KGW  = CW + GW;
	localparam int KLO  = (KGW + 1) / 2;
	localparam int KHI  = KGW - KLO;
	localparam int PW   = KGW + LW;
	localparam int FW   = PW - 2 * FB;
	localparam int FLO  = (FW + 1) / 2;
	localparam int FHI  = FW - FLO;
	localparam int NW   = FW + MW;
	localparam int QW   = CW - 1;
	localparam int RW   = LW + QW;
	localparam int CIW  = 3;

	localparam logic [GW-1:0] ONE_FX    = {1'b1, {FB{1'b0}}};
	localparam logic [CW-1:0] STIFF_RST = {{(CW - FB - 1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic [QW-1:0] MAG_MAX   = '1;

	typedef enum logic [CIW-1:0] {
		REG_ENABLE = CIW'(0),
		REG_REST   = CIW'(1),
		REG_STIFF  = CIW'(2),
		REG_DAMP   = CIW'(3)
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] pos_a_x;
		logic signed [CW-1:0] pos_a_y;
		logic signed [CW-1:0] pos_a_z;
		logic signed [CW-1:0] pos_b_x;
		logic signed [CW-1:0] pos_b_y;
		logic signed [CW-1:0] pos_b_z;
	} pos_t;

	typedef struct packed {
		logic signed [CW-1:0] force_a_x;
		logic signed [CW-1:0] force_a_y;
		logic signed [CW-1:0] force_a_z;
		logic signed [CW-1:0] force_b_x;
		logic signed [CW-1:0] force_b_y;
		logic signed [CW-1:0] force_b_z;
		logic                 applied;
	} frc_t;

	typedef struct packed {
		logic                zero;
		logic [2:0]          dneg;
		logic [2:0][MW-1:0]  dmag;
	} side_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} tag_t;

endpackage

`default_nettype wire

>>> hw/rtl/spring_force_3d.sv
// ----------------------------------------------------------------------------
// spring_force_3d
// Hookean spring force between two point masses, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Input channel pos/pos_valid/pos_stall carries both mass positions; a
// transfer happens when pos_valid is high and pos_stall is low. Output
// channel frc/frc_valid/frc_stall returns the forces on both masses and the
// applied flag, one result per input, in order.
// Configuration writes go over cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high, indexes above the register list are dropped.
// The pipeline registers differences, squares and their sum, then runs the
// bit-per-stage square root, registers the stretch and force products, runs
// the bit-per-stage divider and ends in the output register.
// Throughput is one item per cycle while the receiver does not stall.
// Reset empties the pipeline and loads enable=1, rest_length=0,
// stiffness=1.0, damping=0. When the receiver stalls with a result held in
// the output register, the whole pipeline holds and pos_stall rises in the
// same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_force_3d (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pos_valid,
	output logic                        pos_stall,
	input  sfd_pkg::pos_t               pos,
	output logic                        frc_valid,
	input  logic                        frc_stall,
	output sfd_pkg::frc_t               frc,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sfd_pkg::CIW-1:0]     cfg_index,
	input  logic [sfd_pkg::CW-1:0]      cfg_data
);
	import sfd_pkg::*;

	logic            enable_q;
	logic [RLW-1:0]  rest_q;
	logic [CW-1:0]   stiff_q;
	logic [GW-1:0]   damp_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			rest_q   <= '0;
			stiff_q  <= STIFF_RST;
			damp_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_REST:   rest_q   <= cfg_data[RLW-1:0];
				REG_STIFF:  stiff_q  <= cfg_data;
				REG_DAMP:   damp_q   <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv       = !frc_valid || !frc_stall;
	assign pos_stall = !adv;

	// stage 1: differences
	logic [2:0][CW-1:0] pa;
	logic [2:0][CW-1:0] pb;
	logic [2:0]         dneg_c;
	logic [2:0][MW-1:0] dmag_c;

	assign pa = {pos.pos_a_x, pos.pos_a_y, pos.pos_a_z};
	assign pb = {pos.pos_b_x, pos.pos_b_y, pos.pos_b_z};

	genvar a;
	for (a = 0; a < 3; a++) begin : g_diff
		logic [CW:0] d;
		logic [CW:0] dn;
		assign d         = {pa[a][CW-1], pa[a]} - {pb[a][CW-1], pb[a]};
		assign dn        = -d;
		assign dneg_c[a] = d[CW];
		assign dmag_c[a] = d[CW] ? dn[MW-1:0] : d[MW-1:0];
	end

	logic  v_s1;
	side_t side_s1;

	// stage 2: squares
	logic [2:0][SQW-1:0] sq_c;
	logic                v_s2;
	logic [2:0][SQW-1:0] sq_s2;
	side_t               side_s2;

	for (a = 0; a < 3; a++) begin : g_sq
		assign sq_c[a] = SQW'(side_s1.dmag[a]) * SQW'(side_s1.dmag[a]);
	end

	// stage 3: sum of squares
	logic            v_s3;
	logic [SUMW-1:0] sum_s3;
	side_t           side_s3;

	// square root
	logic          sq_valid;
	logic [LW-1:0] sq_root;
	side_t         sq_side;

	sfd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.in_num    (sum_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// stage 4: stretch, damping gain, stiffness product
	logic           sneg_c;
	logic [LW-1:0]  smag_c;
	logic           gneg_c;
	logic [GW-1:0]  gmag_c;
	logic [KGW-1:0] kg_c;

	assign sneg_c = LW'(rest_q) > sq_root;
	assign smag_c = sneg_c ? (LW'(rest_q) - sq_root) : (sq_root - LW'(rest_q));
	assign gneg_c = damp_q > ONE_FX;
	assign gmag_c = gneg_c ? (damp_q - ONE_FX) : (ONE_FX - damp_q);
	assign kg_c   = KGW'(stiff_q) * KGW'(gmag_c);

	logic           v_s4;
	logic [LW-1:0]  len_s4;
	logic [LW-1:0]  smag_s4;
	logic [KGW-1:0] kg_s4;
	logic           sneg_s4;
	logic           gneg_s4;
	side_t          side_s4;

	// stage 5: stretch partial products
	logic               v_s5;
	logic [KLO+LW-1:0]  plo_s5;
	logic [KHI+LW-1:0]  phi_s5;
	logic [LW-1:0]      len_s5;
	logic               sneg_s5;
	logic               gneg_s5;
	side_t              side_s5;

	// stage 6: force magnitude
	logic [PW-1:0] p_c;
	logic          v_s6;
	logic [FW-1:0] f_s6;
	logic [LW-1:0] len_s6;
	logic          sneg_s6;
	logic          gneg_s6;
	side_t         side_s6;

	assign p_c = PW'(plo_s5) + (PW'(phi_s5) << KLO);

	// stage 7: per-axis partial products
	logic                    v_s7;
	logic [2:0][FLO+MW-1:0]  flo_s7;
	logic [2:0][FHI+MW-1:0]  fhi_s7;
	logic [LW-1:0]           len_s7;
	logic                    sneg_s7;
	logic                    gneg_s7;
	side_t                   side_s7;

	// stage 8: per-axis numerators
	logic                v_s8;
	logic [2:0][NW-1:0]  num_s8;
	tag_t [2:0]          tag_s8;
	logic [LW-1:0]       len_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pos_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= {!enable_q, dneg_c, dmag_c};

			sq_s2   <= sq_c;
			side_s2 <= side_s1;

			sum_s3  <= SUMW'(sq_s2[0]) + SUMW'(sq_s2[1]) + SUMW'(sq_s2[2]);
			side_s3 <= side_s2;

			len_s4  <= sq_root;
			smag_s4 <= smag_c;
			kg_s4   <= kg_c;
			sneg_s4 <= sneg_c;
			gneg_s4 <= gneg_c;
			side_s4 <= {sq_side.zero || (smag_c == '0) || (sq_root == '0),
				sq_side.dneg, sq_side.dmag};

			plo_s5  <= (KLO+LW)'(kg_s4[KLO-1:0]) * (KLO+LW)'(smag_s4);
			phi_s5  <= (KHI+LW)'(kg_s4[KGW-1:KLO]) * (KHI+LW)'(smag_s4);
			len_s5  <= len_s4;
			sneg_s5 <= sneg_s4;
			gneg_s5 <= gneg_s4;
			side_s5 <= side_s4;

			f_s6    <= p_c[PW-1:2*FB];
			len_s6  <= len_s5;
			sneg_s6 <= sneg_s5;
			gneg_s6 <= gneg_s5;
			side_s6 <= side_s5;

			for (int i = 0; i < 3; i++) begin
				flo_s7[i] <= (FLO+MW)'(f_s6[FLO-1:0]) * (FLO+MW)'(side_s6.dmag[i]);
				fhi_s7[i] <= (FHI+MW)'(f_s6[FW-1:FLO]) * (FHI+MW)'(side_s6.dmag[i]);
			end
			len_s7  <= len_s6;
			sneg_s7 <= sneg_s6;
			gneg_s7 <= gneg_s6;
			side_s7 <= side_s6;

			for (int i = 0; i < 3; i++) begin
				num_s8[i] <= NW'(flo_s7[i]) + (NW'(fhi_s7[i]) << FLO);
				tag_s8[i] <= {!(side_s7.dneg[i] ^ sneg_s7 ^ gneg_s7), side_s7.zero};
			end
			len_s8 <= len_s7;
		end
	end

	// dividers, one per axis
	logic [2:0]    dv_valid;
	logic [QW-1:0] dv_quo [3];
	logic [2:0]    dv_sat;
	tag_t          dv_tag [3];

	for (a = 0; a < 3; a++) begin : g_div
		sfd_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (v_s8),
			.in_num    (num_s8[a]),
			.in_den    (len_s8),
			.in_tag    (tag_s8[a]),
			.out_valid (dv_valid[a]),
			.out_quo   (dv_quo[a]),
			.out_sat   (dv_sat[a]),
			.out_tag   (dv_tag[a])
		);
	end

	// output register
	logic [2:0][CW-1:0] fa_c;

	for (a = 0; a < 3; a++) begin : g_out
		logic [CW-1:0] mag;
		assign mag     = {1'b0, (dv_sat[a] ? MAG_MAX : dv_quo[a])};
		assign fa_c[a] = dv_tag[a].zero ? '0 : (dv_tag[a].neg ? -mag : mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frc_valid <= 1'b0;
		end else if (adv) begin
			frc_valid <= &dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frc <= {fa_c[2], fa_c[1], fa_c[0], -fa_c[2], -fa_c[1], -fa_c[0],
				!dv_tag[0].zero};
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/sfd_sqrt.sv
// ----------------------------------------------------------------------------
// sfd_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [sfd_pkg::SUMW-1:0]    in_num,
	input  sfd_pkg::side_t              in_side,
	output logic                        out_valid,
	output logic [sfd_pkg::LW-1:0]      out_root,
	output sfd_pkg::side_t              out_side
);
	import sfd_pkg::*;

	localparam int TW = SUMW + 2;

	logic [LW:0]     v_s;
	logic [SUMW-1:0] rem_s  [LW];
	logic [LW-1:0]   root_s [LW+1];
	side_t           side_s [LW+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = in_num;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	genvar j;
	for (j = 0; j < LW; j++) begin : g_stage
		localparam int K = LW - 1 - j;
		logic [TW-1:0] trial;
		logic          take;
		logic          v_q;
		logic [LW-1:0] root_q;
		side_t         side_q;

		assign trial = (TW'(root_s[j]) << (K + 1)) | (TW'(1) << (2 * K));
		assign take  = TW'(rem_s[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (adv) begin
				v_q <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				root_q <= take ? (root_s[j] | (LW'(1) << K)) : root_s[j];
				side_q <= side_s[j];
			end
		end

		assign v_s[j+1]    = v_q;
		assign root_s[j+1] = root_q;
		assign side_s[j+1] = side_q;

		if (K > 0) begin : g_rem
			logic [SUMW-1:0] rem_q;
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q <= take ? (rem_s[j] - trial[SUMW-1:0]) : rem_s[j];
				end
			end
			assign rem_s[j+1] = rem_q;
		end
	end

	assign out_valid = v_s[LW];
	assign out_root  = root_s[LW];
	assign out_side  = side_s[LW];

endmodule

`default_nettype wire

>>> hw/rtl/sfd_div.sv
// ----------------------------------------------------------------------------
// sfd_div
// Pipelined restoring divider with saturation, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [sfd_pkg::NW-1:0]      in_num,
	input  logic [sfd_pkg::LW-1:0]      in_den,
	input  sfd_pkg::tag_t               in_tag,
	output logic                        out_valid,
	output logic [sfd_pkg::QW-1:0]      out_quo,
	output logic                        out_sat,
	output sfd_pkg::tag_t               out_tag
);
	import sfd_pkg::*;

	logic [QW:0]     v_s;
	logic [RW-1:0]   rem_s [QW];
	logic [LW-1:0]   den_s [QW];
	logic [QW-1:0]   quo_s [QW+1];
	logic            sat_s [QW+1];
	tag_t            tag_s [QW+1];

	logic            v0_q;
	logic [RW-1:0]   rem0_q;
	logic [LW-1:0]   den0_q;
	logic            sat0_q;
	tag_t            tag0_q;
	logic            ovf;

	assign ovf = in_num >= (NW'(in_den) << QW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (adv) begin
			v0_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem0_q <= in_num[RW-1:0];
			den0_q <= in_den;
			sat0_q <= ovf;
			tag0_q <= in_tag;
		end
	end

	assign v_s[0]   = v0_q;
	assign rem_s[0] = rem0_q;
	assign den_s[0] = den0_q;
	assign quo_s[0] = '0;
	assign sat_s[0] = sat0_q;
	assign tag_s[0] = tag0_q;

	genvar j;
	for (j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [RW-1:0] cmp;
		logic          take;
		logic          v_q;
		logic [QW-1:0] quo_q;
		logic          sat_q;
		tag_t          tag_q;

		assign cmp  = RW'(den_s[j]) << K;
		assign take = rem_s[j] >= cmp;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (adv) begin
				v_q <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_q <= take ? (quo_s[j] | (QW'(1) << K)) : quo_s[j];
				sat_q <= sat_s[j];
				tag_q <= tag_s[j];
			end
		end

		assign v_s[j+1]   = v_q;
		assign quo_s[j+1] = quo_q;
		assign sat_s[j+1] = sat_q;
		assign tag_s[j+1] = tag_q;

		if (K > 0) begin : g_rem
			logic [RW-1:0] rem_q;
			logic [LW-1:0] den_q;
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q <= take ? (rem_s[j] - cmp) : rem_s[j];
					den_q <= den_s[j];
				end
			end
			assign rem_s[j+1] = rem_q;
			assign den_s[j+1] = den_q;
		end
	end

	assign out_valid = v_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_sat   = sat_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

`default_nettype wire

>>> hw/rtl/sfd_chk.sv
// ----------------------------------------------------------------------------
// sfd_chk
// Port-level checks on spring_force_3d, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spring_force_3d_assert.svh"

module sfd_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            pos_stall,
	input logic            frc_valid,
	input logic            frc_stall,
	input sfd_pkg::frc_t   frc
);

	logic pair_ok;
	logic idle_ok;

	assign pair_ok = ((frc.force_a_x + frc.force_b_x) == '0) &&
		((frc.force_a_y + frc.force_b_y) == '0) &&
		((frc.force_a_z + frc.force_b_z) == '0);
	assign idle_ok = (frc.force_a_x == '0) && (frc.force_a_y == '0) &&
		(frc.force_a_z == '0);

	`SFD_ASSERT_NEXT(a_out_hold, frc_valid && frc_stall, frc_valid && $stable(frc))
	`SFD_ASSERT_NOW(a_stall_cause, pos_stall, frc_valid && frc_stall)
	`SFD_ASSERT_NOW(a_pair_negated, frc_valid, pair_ok)
	`SFD_ASSERT_NOW(a_idle_zero, frc_valid && !frc.applied, idle_ok)

endmodule

bind spring_force_3d sfd_chk u_sfd_chk (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring force pipeline testbench
// Streams mass position pairs through the block under random source gaps and
// receiver stalls, predicts each force vector from its own fixed-point copy of
// the spring law, and checks every result against the oldest prediction.
// Register settings change only when the pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import sfd_pkg::*;

	localparam int LIMIT = 400000;
	localparam int LAT   = 74;

	class force_board;
		logic        en;
		logic [30:0] rest;
		logic [31:0] stiff;
		logic [16:0] damp;
		frc_t        pending[$];
		int          errors;

		function new();
			en = 1'b1;
			rest = '0;
			stiff = 32'd65536;
			damp = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CIW-1:0] idx, logic [31:0] val);
			case (idx)
				REG_ENABLE: en = val[0];
				REG_REST:   rest = val[30:0];
				REG_STIFF:  stiff = val;
				REG_DAMP:   damp = val[16:0];
				default: ;
			endcase
		endfunction

		function automatic logic [63:0] isqrt(logic [127:0] v);
			logic [127:0] r, b, t;
			r = '0;
			b = 128'd1 << 126;
			while (b != 0) begin
				t = r + b;
				if (v >= t) begin
					v = v - t;
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r[63:0];
		endfunction

		function void note_input(pos_t p);
			frc_t        e;
			logic [63:0] dm[3];
			logic        dn[3];
			logic signed [63:0] d;
			logic [127:0] sq;
			logic [63:0] len, sm, gm, f, mag;
			logic [127:0] prod, q;
			logic        sn, gn, ng;
			logic [31:0] pv, nv;
			logic signed [31:0] pa[3], pb[3];
			e = '0;
			if (en) begin
				pa[0] = p.pos_a_x; pa[1] = p.pos_a_y; pa[2] = p.pos_a_z;
				pb[0] = p.pos_b_x; pb[1] = p.pos_b_y; pb[2] = p.pos_b_z;
				sq = '0;
				for (int i = 0; i < 3; i++) begin
					d = 64'(pa[i]) - 64'(pb[i]);
					dn[i] = d[63];
					dm[i] = dn[i] ? 64'(-d) : 64'(d);
					sq = sq + 128'(dm[i]) * 128'(dm[i]);
				end
				len = isqrt(sq);
				sn = len < 64'(rest);
				sm = sn ? 64'(rest) - len : len - 64'(rest);
				if (sm != 0 && len != 0) begin
					gn = damp > 17'd65536;
					gm = gn ? 64'(damp) - 64'd65536 : 64'd65536 - 64'(damp);
					prod = (128'(stiff) * 128'(gm) * 128'(sm)) >> 32;
					f = (prod > (128'd1 << 62)) ? (64'd1 << 62) : prod[63:0];
					for (int i = 0; i < 3; i++) begin
						q = (128'(f) * 128'(dm[i])) / 128'(len);
						mag = (q > 128'h7fffffff) ? 64'h7fffffff : q[63:0];
						ng = !(dn[i] ^ sn ^ gn);
						pv = mag[31:0];
						nv = -mag[31:0];
						case (i)
							0: begin e.force_a_x = ng ? nv : pv; e.force_b_x = ng ? pv : nv; end
							1: begin e.force_a_y = ng ? nv : pv; e.force_b_y = ng ? pv : nv; end
							default: begin
								e.force_a_z = ng ? nv : pv; e.force_b_z = ng ? pv : nv;
							end
						endcase
					end
					e.applied = 1'b1;
				end
			end
			pending.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			errors++;
		endtask

		task check_result(frc_t r);
			frc_t e;
			if (pending.size() == 0) begin
				report("unexpected transfer", r.force_a_x, '0);
				return;
			end
			e = pending.pop_front();
			if (r.force_a_x !== e.force_a_x) report("force_a_x", r.force_a_x, e.force_a_x);
			if (r.force_a_y !== e.force_a_y) report("force_a_y", r.force_a_y, e.force_a_y);
			if (r.force_a_z !== e.force_a_z) report("force_a_z", r.force_a_z, e.force_a_z);
			if (r.force_b_x !== e.force_b_x) report("force_b_x", r.force_b_x, e.force_b_x);
			if (r.force_b_y !== e.force_b_y) report("force_b_y", r.force_b_y, e.force_b_y);
			if (r.force_b_z !== e.force_b_z) report("force_b_z", r.force_b_z, e.force_b_z);
			if (r.applied !== e.applied) report("applied", 32'(r.applied), 32'(e.applied));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             pos_valid = 1'b0;
	logic             pos_stall;
	pos_t             pos = '0;
	logic             frc_valid;
	logic             frc_stall = 1'b0;
	frc_t             frc;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CIW-1:0]   cfg_index = '0;
	logic [CW-1:0]    cfg_data = '0;
	int               cycles = 0;
	bit               calm = 1'b0;
	force_board       board = new();

	always #4 clk = ~clk;

	spring_force_3d dut (
		.clk(clk), .arst_n(arst_n),
		.pos_valid(pos_valid), .pos_stall(pos_stall), .pos(pos),
		.frc_valid(frc_valid), .frc_stall(frc_stall), .frc(frc),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && frc_valid && !frc_stall) board.check_result(frc);
	end

	// receiver stalls in bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				frc_stall <= 1'b1;
				repeat (n) @(posedge clk);
				frc_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic send(pos_t p);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 7);
			pos_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		pos_valid <= 1'b1;
		pos <= p;
		do @(posedge clk); while (pos_stall);
		board.note_input(p);
	endtask

	task automatic drain();
		pos_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 400000)) - 200000);
			default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
		endcase
	endfunction

	function automatic pos_t rnd_pos();
		pos_t p;
		int   m;
		m = $urandom_range(0, 3);
		p.pos_a_x = rnd_coord(m); p.pos_a_y = rnd_coord(m); p.pos_a_z = rnd_coord(m);
		p.pos_b_x = rnd_coord(m); p.pos_b_y = rnd_coord(m); p.pos_b_z = rnd_coord(m);
		if ($urandom_range(0, 30) == 0) p[95:0] = p[191:96];
		return p;
	endfunction

	task automatic rnd_config();
		write_reg(REG_ENABLE, 32'($urandom_range(0, 5) != 0));
		case ($urandom_range(0, 3))
			0: write_reg(REG_REST, 32'h7fffffff);
			1: write_reg(REG_REST, 0);
			default: write_reg(REG_REST, $urandom_range(0, 32'h01000000));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(REG_STIFF, 32'hffffffff);
			1: write_reg(REG_STIFF, 0);
			default: write_reg(REG_STIFF, $urandom_range(0, 32'h00100000));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(REG_DAMP, 65536);
			1: write_reg(REG_DAMP, 32'h0001ffff);
			default: write_reg(REG_DAMP, $urandom_range(0, 65536));
		endcase
	endtask

	initial begin
		pos_t p;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, extremes, coincident, zero stretch
		p = '0; send(p);
		p = '0; p.pos_a_x = 32'sh00010000; send(p);
		p = '0; p.pos_a_x = 32'sh7fffffff; p.pos_b_x = 32'sh80000000; send(p);
		p = {6{32'sh80000000}}; p.pos_a_y = 32'sh7fffffff; send(p);
		p = {6{32'shffffffff}}; p.pos_b_z = 32'sh7fffffff; send(p);
		p = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000}; send(p);
		drain();
		write_reg(REG_REST, 32'h00010000);
		p = '0; p.pos_b_y = 32'sh00010000; send(p);
		p = '0; p.pos_b_y = 32'sh00008000; send(p);
		p = '0; p.pos_a_z = 32'sh00030000; send(p);
		drain();
		write_reg(REG_DAMP, 65536);
		p = '0; p.pos_a_z = 32'sh00030000; send(p);
		drain();
		write_reg(REG_DAMP, 32'h0001ffff);
		write_reg(REG_STIFF, 32'hffffffff);
		p = '0; p.pos_a_z = 32'sh00030000; send(p);
		p = '0; p.pos_a_x = 32'sh7fffffff; p.pos_b_y = 32'sh80000000; send(p);
		drain();
		write_reg(REG_REST, 32'h7fffffff);
		p = '0; p.pos_a_x = 32'sh00050000; send(p);
		drain();
		write_reg(REG_ENABLE, 0);
		p = '0; p.pos_a_x = 32'sh00050000; send(p);
		drain();
		cfg_index <= 3'd7; cfg_data <= 32'h0; cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		write_reg(REG_ENABLE, 1);
		write_reg(REG_REST, 0);
		write_reg(REG_STIFF, 32'h00010000);
		write_reg(REG_DAMP, 0);

		for (int ph = 0; ph < 10; ph++) begin
			if (ph > 0) rnd_config();
			if (ph == 9) calm = 1'b1;
			for (int k = 0; k < 140; k++) send(rnd_pos());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

`default_nettype wire
